// File: rtl/core/cfov_pkg.sv
`timescale 1ns / 1ps

package cfov_pkg;

    // field widths
    localparam int COORD_BITS = 16;
    localparam int ANGLE_BITS = 16;
    localparam int HALF_FOV_W = 16;
    localparam int RANGE_W    = 15;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // cordic datapath
    localparam int CORDIC_STEPS = 28;
    localparam int Z_W          = 32;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int SCALE_SH     = 60 - COORD_BITS;
    localparam int CORDIC_W     = 64;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [ANGLE_BITS-1:0] t_angle;
    typedef logic signed [ANGLE_BITS-1:0] t_angle_s;
    typedef logic        [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic        [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic signed [CORDIC_W-1:0]   t_cordic;
    typedef logic        [Z_W-1:0]        t_zang;

    // register indexes
    localparam t_cfg_idx REG_HALF_FOV    = t_cfg_idx'(0);
    localparam t_cfg_idx REG_RANGE_LIMIT = t_cfg_idx'(1);

    // reset values
    localparam logic [HALF_FOV_W-1:0] HALF_FOV_RESET = HALF_FOV_W'(7282);
    localparam logic [RANGE_W-1:0]    RANGE_RESET    = RANGE_W'(256);

    // half turn and rounding bit of the 32-bit angle accumulator
    localparam t_zang Z_HALF = t_zang'(1) << (Z_W - 1);
    localparam t_zang Z_RND  = t_zang'(1) << (Z_W - 1 - ANGLE_BITS);

    // arctangent of 2^-i, full turn = 2^32
    localparam t_zang ARC_TABLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

endpackage

// File: rtl/core/cfov_in_if.sv
`timescale 1ns / 1ps

interface cfov_in_if
    import cfov_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord pose_x;
    t_coord pose_y;
    t_angle heading;
    t_coord cone_x;
    t_coord cone_y;

    modport source (
        output valid, pose_x, pose_y, heading, cone_x, cone_y,
        input  ready
    );
    modport sink (
        input  valid, pose_x, pose_y, heading, cone_x, cone_y,
        output ready
    );
endinterface

// File: rtl/core/cfov_out_if.sv
`timescale 1ns / 1ps

interface cfov_out_if
    import cfov_pkg::*;
();
    logic     valid;
    logic     ready;
    logic     visible;
    t_coord   out_cone_x;
    t_coord   out_cone_y;
    t_angle_s relative_bearing;

    modport source (
        output valid, visible, out_cone_x, out_cone_y, relative_bearing,
        input  ready
    );
    modport sink (
        input  valid, visible, out_cone_x, out_cone_y, relative_bearing,
        output ready
    );
endinterface

// File: rtl/core/cfov_cfg_if.sv
`timescale 1ns / 1ps

interface cfov_cfg_if
    import cfov_pkg::*;
();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: rtl/core/cfov_cordic.sv
`timescale 1ns / 1ps

module cfov_cordic
    import cfov_pkg::*;
(
    input  logic                    i_clk,
    input  logic [CORDIC_STEPS-1:0] i_en,
    input  t_cordic                 i_x,
    input  t_cordic                 i_y,
    input  t_zang                   i_z,
    output t_zang                   o_z
);

    // stage inputs: stage 0 takes the port, later stages the registers before
    t_cordic w_x [CORDIC_STEPS];
    t_cordic w_y [CORDIC_STEPS];
    t_zang   w_z [CORDIC_STEPS];

    t_cordic r_x [CORDIC_STEPS-1];
    t_cordic r_y [CORDIC_STEPS-1];
    t_zang   r_z [CORDIC_STEPS];

    assign w_x[0] = i_x;
    assign w_y[0] = i_y;
    assign w_z[0] = i_z;

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_stage
            logic w_up;

            if (i > 0) begin : g_link
                assign w_x[i] = r_x[i-1];
                assign w_y[i] = r_y[i-1];
                assign w_z[i] = r_z[i-1];
            end

            // rotate toward the x axis, angle rises while y is above it
            assign w_up = !w_y[i][CORDIC_W-1] && (w_y[i] != '0);

            always_ff @(posedge i_clk) begin
                if (i_en[i]) begin
                    r_z[i] <= w_up ? (w_z[i] + ARC_TABLE[i]) : (w_z[i] - ARC_TABLE[i]);
                end
            end

            // the last step only needs the angle
            if (i < CORDIC_STEPS - 1) begin : g_xy
                t_cordic w_xs;
                t_cordic w_ys;

                assign w_xs = w_x[i] >>> i;
                assign w_ys = w_y[i] >>> i;

                always_ff @(posedge i_clk) begin
                    if (i_en[i]) begin
                        r_x[i] <= w_up ? (w_x[i] + w_ys) : (w_x[i] - w_ys);
                        r_y[i] <= w_up ? (w_y[i] - w_xs) : (w_y[i] + w_xs);
                    end
                end
            end
        end
    endgenerate

    assign o_z = r_z[CORDIC_STEPS-1];

endmodule

// File: rtl/core/cone_field_of_view_filter.sv
`timescale 1ns / 1ps

// Cone field-of-view filter. Each word on the input channel carries the
// vehicle pose and one cone position; the block returns one word per cone
// with the cone passed through, its bearing relative to the heading and a
// visible flag (bearing within half_fov_angle and distance within
// range_limit, compared as squares). The pipeline is 32 register stages
// deep, and a new cone is accepted every clock unless a stalled output
// has filled it; the 28 unrolled CORDIC vectoring stages make up most of
// that depth, one iteration per stage. A stall at the output holds the
// results in place while bubbles further up still close, so input keeps
// flowing until the pipeline is full. Registers are written through the
// configuration channel, which is always ready: index 0 is half_fov_angle,
// index 1 is range_limit, other indexes are ignored. Write them only while
// no cone is in flight.
module cone_field_of_view_filter
    import cfov_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfov_cfg_if.sink    i_cfg,
    cfov_in_if.sink     i_in,
    cfov_out_if.source  o_out
);

    // stage numbers
    localparam int S_ROT = 1;
    localparam int S_CRD = 2;
    localparam int S_SQ  = 2;
    localparam int S_SUM = 3;
    localparam int S_BRG = S_CRD + CORDIC_STEPS;
    localparam int S_OUT = S_BRG + 1;
    localparam int NS    = S_OUT + 1;

    localparam int RCMP_W = (COORD_BITS > RANGE_W) ? COORD_BITS : RANGE_W;
    localparam int FCMP_W = (ANGLE_BITS > HALF_FOV_W) ? ANGLE_BITS : HALF_FOV_W;
    localparam int SQ_W   = 2 * RANGE_W;
    localparam int SUM_W  = SQ_W + 1;

    typedef logic signed [DIFF_W-1:0] t_diff;

    typedef struct packed {
        t_coord cone_x;
        t_coord cone_y;
        t_angle heading;
        logic   zero;
        logic   pre;
        logic   in_range;
    } t_side;

    // configuration registers
    logic [HALF_FOV_W-1:0] r_half_fov;
    logic [RANGE_W-1:0]    r_range_limit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_fov    <= HALF_FOV_RESET;
            r_range_limit <= RANGE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_HALF_FOV:    r_half_fov    <= i_cfg.data[HALF_FOV_W-1:0];
                REG_RANGE_LIMIT: r_range_limit <= i_cfg.data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables: a stage moves when the output is ready or any stage at or after it is empty
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] w_en;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_en[k] = o_out.ready || (((~r_v) & ({NS{1'b1}} << k)) != '0);
        end
    end

    assign n_v        = {r_v[NS-2:0], i_in.valid};
    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    // side data that travels with each word
    t_side r_side [NS];
    t_side n_side [NS];

    // stage 0: offsets from vehicle to cone
    t_diff r_dx;
    t_diff r_dy;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_dx <= t_diff'(i_in.cone_x) - t_diff'(i_in.pose_x);
            r_dy <= t_diff'(i_in.cone_y) - t_diff'(i_in.pose_y);
        end
    end

    // stage 1: fold into right half plane, scale, range prefilter
    logic                  w_neg;
    t_diff                 w_xr;
    t_diff                 w_yr;
    t_diff                 w_adx;
    t_diff                 w_ady;
    logic [RCMP_W-1:0]     w_adx_e;
    logic [RCMP_W-1:0]     w_ady_e;
    logic [RCMP_W-1:0]     w_rl_e;
    logic                  w_pre;
    t_cordic               r_x0;
    t_cordic               r_y0;
    t_zang                 r_z0;
    logic [RANGE_W-1:0]    r_ax;
    logic [RANGE_W-1:0]    r_ay;

    assign w_neg   = r_dx[DIFF_W-1];
    assign w_xr    = w_neg ? -r_dx : r_dx;
    assign w_yr    = w_neg ? -r_dy : r_dy;
    assign w_adx   = r_dx[DIFF_W-1] ? -r_dx : r_dx;
    assign w_ady   = r_dy[DIFF_W-1] ? -r_dy : r_dy;
    assign w_adx_e = RCMP_W'(w_adx[COORD_BITS-1:0]);
    assign w_ady_e = RCMP_W'(w_ady[COORD_BITS-1:0]);
    assign w_rl_e  = RCMP_W'(r_range_limit);
    assign w_pre   = (w_adx_e <= w_rl_e) && (w_ady_e <= w_rl_e);

    always_ff @(posedge i_clk) begin
        if (w_en[S_ROT]) begin
            r_x0 <= t_cordic'(w_xr) <<< SCALE_SH;
            r_y0 <= t_cordic'(w_yr) <<< SCALE_SH;
            r_z0 <= w_neg ? Z_HALF : '0;
            r_ax <= w_adx_e[RANGE_W-1:0];
            r_ay <= w_ady_e[RANGE_W-1:0];
        end
    end

    // stage 2: squares of the offsets and the limit
    logic [SQ_W-1:0] r_sqx;
    logic [SQ_W-1:0] r_sqy;
    logic [SQ_W-1:0] r_rl2;

    always_ff @(posedge i_clk) begin
        if (w_en[S_SQ]) begin
            r_sqx <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_sqy <= SQ_W'(r_ay) * SQ_W'(r_ay);
            r_rl2 <= SQ_W'(r_range_limit) * SQ_W'(r_range_limit);
        end
    end

    // stage 3: squared distance against squared limit
    logic w_in_range;

    assign w_in_range = r_side[S_SUM-1].pre &&
                        ((SUM_W'(r_sqx) + SUM_W'(r_sqy)) <= SUM_W'(r_rl2));

    // stages 2 to 29: cordic vectoring
    t_zang w_z;

    cfov_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (w_en[S_CRD +: CORDIC_STEPS]),
        .i_x   (r_x0),
        .i_y   (r_y0),
        .i_z   (r_z0),
        .o_z   (w_z)
    );

    // stage 30: round bearing, take it relative to heading
    t_zang  w_zr;
    t_angle w_bearing;
    t_angle r_rel;

    assign w_zr      = w_z + Z_RND;
    assign w_bearing = r_side[S_BRG-1].zero ? '0 : w_zr[Z_W-1 -: ANGLE_BITS];

    always_ff @(posedge i_clk) begin
        if (w_en[S_BRG]) begin
            r_rel <= w_bearing - r_side[S_BRG-1].heading;
        end
    end

    // stage 31: field of view test and output word
    t_angle   w_mag;
    logic     w_in_fov;
    logic     r_vis;
    t_angle_s r_rel_o;

    assign w_mag    = r_rel[ANGLE_BITS-1] ? (~r_rel + t_angle'(1)) : r_rel;
    assign w_in_fov = FCMP_W'(w_mag) <= FCMP_W'(r_half_fov);

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            r_vis   <= r_side[S_OUT-1].in_range && w_in_fov;
            r_rel_o <= t_angle_s'(r_rel);
        end
    end

    // side data next values
    always_comb begin
        n_side[0] = '{
            cone_x:   i_in.cone_x,
            cone_y:   i_in.cone_y,
            heading:  i_in.heading,
            zero:     1'b0,
            pre:      1'b0,
            in_range: 1'b0
        };
        for (int k = 1; k < NS; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[S_ROT].zero     = (r_dx == '0) && (r_dy == '0);
        n_side[S_ROT].pre      = w_pre;
        n_side[S_SUM].in_range = w_in_range;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_en[k]) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    // output channel
    assign o_out.valid            = r_v[NS-1];
    assign o_out.visible          = r_vis;
    assign o_out.out_cone_x       = r_side[NS-1].cone_x;
    assign o_out.out_cone_y       = r_side[NS-1].cone_y;
    assign o_out.relative_bearing = r_rel_o;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cfov_pkg::*;

    localparam int DIR_ROWS    = 25;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_OFF    = 120;
    localparam int DRAIN_PAUSE = 40;
    localparam int WATCHDOG    = 3000;
    localparam int PRESCALE    = 60 - COORD_BITS;
    localparam int ATAN_STEPS  = 28;

    // indexes outside the register map, writes there must be dropped
    localparam t_cfg_idx REG_UNUSED  = t_cfg_idx'(2);
    localparam t_cfg_idx REG_TOP_IDX = t_cfg_idx'(255);

    // atan(2^-i) as a fraction of a full turn, turn = 2^32
    localparam bit [31:0] ATAN_TURNS [ATAN_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef struct packed {
        t_coord pose_x;
        t_coord pose_y;
        t_angle heading;
        t_coord cone_x;
        t_coord cone_y;
    } t_cone_req;

    typedef struct packed {
        logic     visible;
        t_coord   cone_x;
        t_coord   cone_y;
        t_angle_s bearing;
    } t_cone_res;

    typedef struct packed {
        t_coord   pose_x;
        t_coord   pose_y;
        t_angle   heading;
        t_coord   cone_x;
        t_coord   cone_y;
        logic     typed;
        logic     exp_visible;
        t_angle_s exp_bearing;
    } t_dir_row;

    // directed words, expected values typed in only for cones sitting on the vehicle
    t_dir_row dir_table [DIR_ROWS] = '{
        '{16'sd0, 16'sd0, 16'h0000, 16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0},
        '{16'sd100, 16'sd100, 16'h8000, 16'sd100, 16'sd100, 1'b1, 1'b0, 16'sh8000},
        '{16'sh8000, 16'sh8000, 16'hFFFF, 16'sh8000, 16'sh8000, 1'b1, 1'b1, 16'sd1},
        '{16'sh7FFF, 16'sh7FFF, 16'h1C72, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, -16'sd7282},
        '{16'sd0, 16'sd0, 16'h1C73, 16'sd0, 16'sd0, 1'b1, 1'b0, -16'sd7283},
        '{16'sd0, 16'sd0, 16'hE38E, 16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd7282},
        '{16'sh8000, 16'sd0, 16'h0000, 16'sh7FFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
        '{16'sh7FFF, 16'sd0, 16'h0000, 16'sh8000, 16'sd0, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sh8000, 16'h0000, 16'sd0, 16'sh7FFF, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sh7FFF, 16'h0000, 16'sd0, 16'sh8000, 1'b0, 1'b0, 16'sd0},
        '{16'sh8000, 16'sh8000, 16'h0000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 16'sd0},
        '{16'sh7FFF, 16'sh7FFF, 16'h0000, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h0000, 16'sd256, 16'sd0, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h0000, 16'sd257, 16'sd0, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h0000, 16'sd181, 16'sd181, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h0000, 16'sd182, 16'sd181, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h0000, -16'sd100, 16'sd0, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h8000, -16'sd100, 16'sd0, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h4000, 16'sd0, 16'sd200, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h0000, 16'sd100, 16'sd50, 1'b0, 1'b0, 16'sd0},
        '{16'sd500, -16'sd500, 16'hC000, 16'sd500, -16'sd700, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h7FFF, -16'sd50, -16'sd50, 1'b0, 1'b0, 16'sd0},
        '{16'sd10, 16'sd10, 16'h0000, -16'sd120, 16'sd90, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h0000, 16'sd0, -16'sd256, 1'b0, 1'b0, 16'sd0},
        '{16'sd0, 16'sd0, 16'h0000, 16'sd300, 16'sd10, 1'b0, 1'b0, 16'sd0}
    };

    logic i_clk;
    logic i_rst_n;

    cfov_cfg_if cfg_bus ();
    cfov_in_if  cone_bus ();
    cfov_out_if result_bus ();

    cone_field_of_view_filter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (cone_bus),
        .o_out   (result_bus)
    );

    // register mirror
    logic [15:0] fov_cfg;
    logic [14:0] range_cfg;

    t_cone_res pending_cones [$];
    t_cone_res oldest_cone;
    int        mismatch_count;
    int        burst_left;
    bit        hold_req;

    // cordic vectoring bearing of (dx, dy), binary angle
    function automatic t_angle cone_bearing(input longint dx_in, input longint dy_in);
        longint    dx;
        longint    dy;
        longint    x;
        longint    y;
        longint    xs;
        longint    ys;
        bit [31:0] z;
        dx = dx_in;
        dy = dy_in;
        z  = 32'h0;
        if (dx == 0 && dy == 0) return t_angle'(0);
        // fold the left half plane over, start from a half turn
        if (dx < 0) begin
            dx = -dx;
            dy = -dy;
            z  = 32'h8000_0000;
        end
        x = dx <<< PRESCALE;
        y = dy <<< PRESCALE;
        for (int i = 0; i < ATAN_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        // round to nearest angle step
        z = z + 32'h0000_8000;
        return t_angle'(z >> 16);
    endfunction

    // visibility and relative bearing of one cone under the current registers
    function automatic t_cone_res predict_cone(input t_cone_req req);
        longint    dx;
        longint    dy;
        longint    adx;
        longint    ady;
        longint    rl;
        logic      in_range;
        t_angle    rel;
        logic [16:0] mag;
        t_cone_res res;
        dx  = longint'(req.cone_x) - longint'(req.pose_x);
        dy  = longint'(req.cone_y) - longint'(req.pose_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        rl  = longint'(range_cfg);
        in_range = (adx <= rl) && (ady <= rl) && (adx * adx + ady * ady <= rl * rl);
        rel = cone_bearing(dx, dy) - req.heading;
        mag = rel[15] ? (17'h10000 - {1'b0, rel}) : {1'b0, rel};
        res.visible = in_range && (mag <= {1'b0, fov_cfg});
        res.cone_x  = req.cone_x;
        res.cone_y  = req.cone_y;
        res.bearing = t_angle_s'(rel);
        return res;
    endfunction

    // mostly cones near the vehicle, the rest anywhere
    function automatic t_cone_req random_cone();
        t_cone_req req;
        int        span;
        int        mode;
        mode = int'($urandom_range(0, 19));
        span = 2 * int'(range_cfg) + 2;
        req.pose_x  = t_coord'($urandom);
        req.pose_y  = t_coord'($urandom);
        req.heading = t_angle'($urandom);
        if (mode == 0) begin
            req.cone_x = req.pose_x;
            req.cone_y = req.pose_y;
        end else if (mode < 13) begin
            req.cone_x = t_coord'(int'(req.pose_x) + int'($urandom_range(0, span)) - span / 2);
            req.cone_y = t_coord'(int'(req.pose_y) + int'($urandom_range(0, span)) - span / 2);
        end else begin
            req.cone_x = t_coord'($urandom);
            req.cone_y = t_coord'($urandom);
        end
        return req;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // register write, mirror updated on the handshake
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            REG_HALF_FOV: begin
                fov_cfg = val;
            end
            REG_RANGE_LIMIT: begin
                range_cfg = val[14:0];
            end
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // offer one cone word, bursts separated by random gaps
    task automatic offer_cone(input t_cone_req req, input logic typed,
                              input t_cone_res typed_res);
        int        gap;
        t_cone_res want;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap > 0) begin
                @(negedge i_clk);
                cone_bus.valid  = 1'b0;
                cone_bus.pose_x = t_coord'($urandom);
                cone_bus.cone_y = t_coord'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = int'($urandom_range(1, 24));
        end
        burst_left--;
        @(negedge i_clk);
        cone_bus.valid   = 1'b1;
        cone_bus.pose_x  = req.pose_x;
        cone_bus.pose_y  = req.pose_y;
        cone_bus.heading = req.heading;
        cone_bus.cone_x  = req.cone_x;
        cone_bus.cone_y  = req.cone_y;
        do @(posedge i_clk); while (!cone_bus.ready);
        want = typed ? typed_res : predict_cone(req);
        pending_cones = {pending_cones, want};
    endtask

    // wait for the pipeline to empty, then let it settle
    task automatic drain_results();
        while (pending_cones.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result receiver, random ready runs and one long hold-off on request
    initial begin
        int run;
        int stall;
        result_bus.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (hold_req) begin
                @(negedge i_clk);
                result_bus.ready = 1'b0;
                repeat (HOLD_OFF - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                run   = int'($urandom_range(1, 40));
                stall = int'($urandom_range(0, 5));
                @(negedge i_clk);
                result_bus.ready = 1'b1;
                repeat (run - 1) @(negedge i_clk);
                if (stall > 0) begin
                    @(negedge i_clk);
                    result_bus.ready = 1'b0;
                    repeat (stall - 1) @(negedge i_clk);
                end
            end
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_cones.size() == 0) begin
                $display("%0t unexpected word: expected none, got x %0d y %0d bearing %0d vis %0b",
                         $time, result_bus.out_cone_x, result_bus.out_cone_y,
                         result_bus.relative_bearing, result_bus.visible);
                mismatch_count++;
            end else begin
                oldest_cone = pending_cones.pop_front();
                check_field("visible", int'(oldest_cone.visible), int'(result_bus.visible));
                check_field("out_cone_x", int'(oldest_cone.cone_x), int'(result_bus.out_cone_x));
                check_field("out_cone_y", int'(oldest_cone.cone_y), int'(result_bus.out_cone_y));
                check_field("relative_bearing", int'(oldest_cone.bearing),
                            int'(result_bus.relative_bearing));
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG) begin
            @(posedge i_clk);
            if ((cone_bus.valid && cone_bus.ready) || (result_bus.valid && result_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t watchdog expired, %0d words outstanding", $time, pending_cones.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus
    initial begin
        t_dir_row  row;
        t_cone_req req;
        t_cone_res typed_res;
        i_rst_n          = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_HALF_FOV;
        cfg_bus.data     = '0;
        cone_bus.valid   = 1'b0;
        cone_bus.pose_x  = '0;
        cone_bus.pose_y  = '0;
        cone_bus.heading = '0;
        cone_bus.cone_x  = '0;
        cone_bus.cone_y  = '0;
        fov_cfg          = 16'd7282;
        range_cfg        = 15'd256;
        mismatch_count   = 0;
        burst_left       = 0;
        hold_req         = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words under the reset register values
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_table[r];
            req.pose_x  = row.pose_x;
            req.pose_y  = row.pose_y;
            req.heading = row.heading;
            req.cone_x  = row.cone_x;
            req.cone_y  = row.cone_y;
            typed_res.visible = row.exp_visible;
            typed_res.cone_x  = row.cone_x;
            typed_res.cone_y  = row.cone_y;
            typed_res.bearing = row.exp_bearing;
            offer_cone(req, row.typed, typed_res);
        end

        // random phases, registers rewritten between them while idle
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                @(negedge i_clk);
                cone_bus.valid = 1'b0;
                drain_results();
                case (phase)
                    1: begin
                        write_reg(REG_HALF_FOV, 16'h0000);
                        write_reg(REG_RANGE_LIMIT, 16'h0000);
                    end
                    2: begin
                        write_reg(REG_HALF_FOV, 16'h8000);
                        write_reg(REG_RANGE_LIMIT, 16'h7FFF);
                    end
                    3: begin
                        // wide fov accepts every bearing, range data bit 15 is masked off
                        write_reg(REG_HALF_FOV, 16'hFFFF);
                        write_reg(REG_RANGE_LIMIT, 16'hFFFF);
                        write_reg(REG_UNUSED, 16'h0001);
                        write_reg(REG_TOP_IDX, 16'h0000);
                    end
                    4: begin
                        write_reg(REG_HALF_FOV, t_cfg_data'($urandom_range(0, 32768)));
                        write_reg(REG_RANGE_LIMIT, t_cfg_data'($urandom_range(1, 4000)));
                    end
                    default: begin
                        write_reg(REG_RANGE_LIMIT, 16'd1024);
                        write_reg(REG_HALF_FOV, 16'd7282);
                    end
                endcase
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long output hold-off while the input keeps streaming
                if (phase == 2 && n == 20) begin
                    hold_req   = 1'b1;
                    burst_left = 80;
                end
                offer_cone(random_cone(), 1'b0, typed_res);
            end
        end

        @(negedge i_clk);
        cone_bus.valid = 1'b0;
        drain_results();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
